// File: src/dpf_pkg.sv
package dpf_pkg;

  // Field widths fixed by the request format
  localparam int unsigned SRC_W  = 16;
  localparam int unsigned DST_W  = 16;
  localparam int unsigned TS_W   = 30;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned LIM_W  = 7;
  localparam int unsigned CNT_W  = 7;

  // Request codes; the fourth code is unused and gives an empty result
  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FWD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CNT = 2'd2;

  // Limit after reset
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

  // One held packet
  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [DST_W-1:0] dst;
    logic [TS_W-1:0]  ts;
  } entry_t;

endpackage

// File: src/dedup_packet_fifo_with_range_count_top.sv
// Packet FIFO holding up to mem_limit (source, destination, timestamp) entries
// in arrival order, with a duplicate filter on add and a destination/time-range
// count. One request is taken at a time; in_stall_o is high while it is worked
// on, and each request gives exactly one result on the output register, which
// holds it until taken. Add and count scan every held entry through the single
// read port of the entry memory, one entry per cycle.
// A limit of 0 acts as 1 and a limit above DEPTH acts as DEPTH; lowering the
// limit drops nothing at once, later adds evict one oldest entry each.
module dedup_packet_fifo_with_range_count_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [dpf_pkg::LIM_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [dpf_pkg::REQ_W-1:0]   req_type_i,
  input  logic [dpf_pkg::SRC_W-1:0]   src_id_i,
  input  logic [dpf_pkg::DST_W-1:0]   dest_id_i,
  input  logic [dpf_pkg::TS_W-1:0]    time_stamp_i,
  input  logic [dpf_pkg::TS_W-1:0]    range_start_i,
  input  logic [dpf_pkg::TS_W-1:0]    range_end_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        add_accepted_o,
  output logic                        fwd_valid_o,
  output logic [dpf_pkg::SRC_W-1:0]   fwd_source_o,
  output logic [dpf_pkg::DST_W-1:0]   fwd_dest_o,
  output logic [dpf_pkg::TS_W-1:0]    fwd_time_o,
  output logic [dpf_pkg::CNT_W-1:0]   match_count_o
);
  import dpf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > LIM_W) ? CW : LIM_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FWD,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [LIM_W-1:0] limit_q;
  logic [PW-1:0]    head_q, tail_q, ptr_q;
  logic [CW-1:0]    occ_q, idx_q;
  logic             scan_vld_q;
  logic             dup_q;
  logic [CNT_W-1:0] cnt_q;

  // latched request
  logic [REQ_W-1:0] req_q;
  logic [SRC_W-1:0] src_q;
  logic [DST_W-1:0] dst_q;
  logic [TS_W-1:0]  ts_q, rs_q, re_q;

  // result register
  logic             out_valid_q;
  logic             add_acc_q, fwd_vld_q;
  logic [SRC_W-1:0] fwd_src_q;
  logic [DST_W-1:0] fwd_dst_q;
  logic [TS_W-1:0]  fwd_ts_q;
  logic [CNT_W-1:0] match_q;

  // entry memory
  entry_t           mem_q [DEPTH];
  entry_t           rd_data_q;
  logic             rd_en, wr_en;
  logic [PW-1:0]    rd_addr;

  logic             in_acc, out_free;
  logic             hit_dup, hit_cnt;
  logic [LW-1:0]    lim_ext;
  logic [CW-1:0]    lim;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // effective limit, clamped to 1..DEPTH
  always_comb begin
    lim_ext = LW'(limit_q);
    if (limit_q == '0) begin
      lim = CW'(1);
    end else if (lim_ext > LW'(DEPTH)) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(lim_ext);
    end
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q;
    unique case (state_q)
      S_SCAN: rd_en = (idx_q != occ_q);
      S_FWD: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      default: rd_en = 1'b0;
    endcase
    wr_en = (state_q == S_RESP) && out_free && (req_q == REQ_ADD) && !dup_q;
  end

  // shared compare unit on the registered read data
  assign hit_dup = (rd_data_q.src == src_q) && (rd_data_q.dst == dst_q) &&
                   (rd_data_q.ts == ts_q);
  assign hit_cnt = (rd_data_q.dst == dst_q) && (rd_data_q.ts >= rs_q) &&
                   (rd_data_q.ts <= re_q);

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= '{src: src_q, dst: dst_q, ts: ts_q};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIM_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // sequencer, queue pointers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      idx_q       <= '0;
      ptr_q       <= '0;
      scan_vld_q  <= 1'b0;
      dup_q       <= 1'b0;
      cnt_q       <= '0;
      req_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      ts_q        <= '0;
      rs_q        <= '0;
      re_q        <= '0;
      out_valid_q <= 1'b0;
      add_acc_q   <= 1'b0;
      fwd_vld_q   <= 1'b0;
      fwd_src_q   <= '0;
      fwd_dst_q   <= '0;
      fwd_ts_q    <= '0;
      match_q     <= '0;
    end else begin
      // result taken downstream; a new one in S_RESP sets it again below
      if (out_valid_q && !out_stall_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q <= req_type_i;
            src_q <= src_id_i;
            dst_q <= dest_id_i;
            ts_q  <= time_stamp_i;
            rs_q  <= range_start_i;
            re_q  <= range_end_i;
            idx_q <= '0;
            ptr_q <= head_q;
            dup_q <= 1'b0;
            cnt_q <= '0;
            scan_vld_q <= 1'b0;
            if (req_type_i == REQ_ADD || req_type_i == REQ_CNT) begin
              state_q <= S_SCAN;
            end else if (req_type_i == REQ_FWD) begin
              state_q <= S_FWD;
            end else begin
              state_q <= S_RESP;
            end
          end
        end

        S_SCAN: begin
          // issue one read per cycle, compare its data in the next cycle
          if (rd_en) begin
            ptr_q <= ptr_next(ptr_q);
            idx_q <= idx_q + 1'b1;
          end
          scan_vld_q <= rd_en;
          if (scan_vld_q) begin
            if (req_q == REQ_ADD && hit_dup) begin
              dup_q <= 1'b1;
            end
            if (req_q == REQ_CNT && hit_cnt && cnt_q != CNT_MAX) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          if (!rd_en && !scan_vld_q) begin
            state_q <= S_RESP;
          end
        end

        S_FWD: state_q <= S_RESP;

        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            add_acc_q   <= 1'b0;
            fwd_vld_q   <= 1'b0;
            fwd_src_q   <= '0;
            fwd_dst_q   <= '0;
            fwd_ts_q    <= '0;
            match_q     <= '0;
            case (req_q)
              REQ_ADD: begin
                if (!dup_q) begin
                  add_acc_q <= 1'b1;
                  tail_q    <= ptr_next(tail_q);
                  // full at the limit: oldest goes, count stays
                  if (occ_q >= lim) begin
                    head_q <= ptr_next(head_q);
                  end else begin
                    occ_q <= occ_q + 1'b1;
                  end
                end
              end
              REQ_FWD: begin
                if (occ_q != '0) begin
                  fwd_vld_q <= 1'b1;
                  fwd_src_q <= rd_data_q.src;
                  fwd_dst_q <= rd_data_q.dst;
                  fwd_ts_q  <= rd_data_q.ts;
                  head_q    <= ptr_next(head_q);
                  occ_q     <= occ_q - 1'b1;
                end
              end
              REQ_CNT: match_q <= cnt_q;
              default: match_q <= '0;
            endcase
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign add_accepted_o = add_acc_q;
  assign fwd_valid_o    = fwd_vld_q;
  assign fwd_source_o   = fwd_src_q;
  assign fwd_dest_o     = fwd_dst_q;
  assign fwd_time_o     = fwd_ts_q;
  assign match_count_o  = match_q;

  // occupancy never exceeds the memory depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted request left sequencer idle");

  // compare data only arrives during a scan
  a_scan_vld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_vld_q |-> (state_q == S_SCAN))
    else $error("scan compare outside scan");

  // a scan never reads past the held entries
  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= occ_q))
    else $error("scan index past occupancy");

endmodule
